@@ hdl/ifp_pkg.sv @@
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared constants and types for the imu serial frame parser: frame byte
// positions, reset header value and the parsed frame record.
// ----------------------------------------------------------------------------
package ifp_pkg;

	// frame layout, positions of the next expected byte (0 = hunting)
	localparam int unsigned POS_W          = 5;
	localparam logic [POS_W-1:0] POS_HUNT       = 5'd0;
	localparam logic [POS_W-1:0] POS_WORD_LAST  = 5'd18;
	localparam logic [POS_W-1:0] POS_STATUS     = 5'd19;
	localparam logic [POS_W-1:0] POS_CK_LOW     = 5'd20;
	localparam logic [POS_W-1:0] POS_FRAME_LAST = 5'd21;

	localparam int unsigned WORD_COUNT = 9;
	localparam int unsigned WORD_IDX_W = 4;

	localparam logic [7:0] HEADER_RESET = 8'hAA;

	// word slots inside a frame
	localparam int unsigned IDX_GYRO_X  = 0;
	localparam int unsigned IDX_GYRO_Y  = 1;
	localparam int unsigned IDX_GYRO_Z  = 2;
	localparam int unsigned IDX_ACCEL_X = 3;
	localparam int unsigned IDX_ACCEL_Y = 4;
	localparam int unsigned IDX_ACCEL_Z = 5;
	localparam int unsigned IDX_ROLL    = 6;
	localparam int unsigned IDX_PITCH   = 7;
	localparam int unsigned IDX_YAW     = 8;

	// one completed frame
	typedef struct packed {
		logic [WORD_COUNT-1:0][15:0] words;
		logic [7:0]                  status;
		logic                        ck_ok;
	} frame_t;

	// parser status seen by the top level
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             emit;
	} parse_stat_t;

endpackage

@@ hdl/ifp_parser.sv @@
// ----------------------------------------------------------------------------
// ifp_parser
// Byte position tracker: hunts for the header, stores the frame words and
// status, keeps the running 16-bit sum and builds the frame on its last byte.
// ----------------------------------------------------------------------------
module ifp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [7:0]           cfg_data,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output ifp_pkg::frame_t      frame,
	output ifp_pkg::parse_stat_t stat
);

	logic [ifp_pkg::POS_W-1:0]      pos_q;
	logic [ifp_pkg::POS_W-1:0]      pos_next;
	logic [15:0]                    sum_q;
	logic [15:0]                    sum_next;
	logic [7:0]                     ck_low_q;
	logic [7:0]                     header_q;
	logic [15:0]                    words_q [ifp_pkg::WORD_COUNT];
	logic [7:0]                     status_q;
	logic [ifp_pkg::POS_W-1:0]      pos_m1;
	logic [ifp_pkg::WORD_IDX_W-1:0] word_idx;
	logic                           in_word;
	logic                           hi_byte;
	logic                           emit;

	// header register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= ifp_pkg::HEADER_RESET;
		end else if (cfg_wr) begin
			header_q <= cfg_data;
		end
	end

	// decode of the current position
	assign pos_m1   = pos_q - 5'd1;
	assign word_idx = pos_m1[ifp_pkg::WORD_IDX_W:1];
	assign in_word  = (pos_q != ifp_pkg::POS_HUNT) && (pos_q <= ifp_pkg::POS_WORD_LAST);
	assign hi_byte  = pos_q[0];
	assign emit     = accept && (pos_q == ifp_pkg::POS_FRAME_LAST);

	// next position and running sum
	always_comb begin
		pos_next = pos_q;
		sum_next = sum_q;
		if (pos_q == ifp_pkg::POS_HUNT) begin
			if (rx_byte == header_q) begin
				pos_next = 5'd1;
				sum_next = {8'h00, rx_byte};
			end
		end else if (in_word) begin
			pos_next = pos_q + 5'd1;
			sum_next = sum_q + (hi_byte ? {rx_byte, 8'h00} : {8'h00, rx_byte});
		end else if (pos_q == ifp_pkg::POS_STATUS) begin
			pos_next = pos_q + 5'd1;
			sum_next = sum_q + {rx_byte, 8'h00};
		end else if (pos_q == ifp_pkg::POS_CK_LOW) begin
			pos_next = pos_q + 5'd1;
		end else begin
			// last checksum byte or an unused position: back to hunting
			pos_next = ifp_pkg::POS_HUNT;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= ifp_pkg::POS_HUNT;
			sum_q    <= '0;
			ck_low_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
			sum_q <= sum_next;
			if (pos_q == ifp_pkg::POS_CK_LOW) begin
				ck_low_q <= rx_byte;
			end
		end
	end

	// frame payload storage
	always_ff @(posedge clk) begin
		if (accept && in_word) begin
			if (hi_byte) begin
				words_q[word_idx] <= {rx_byte, 8'h00};
			end else begin
				words_q[word_idx][7:0] <= rx_byte;
			end
		end
		if (accept && (pos_q == ifp_pkg::POS_STATUS)) begin
			status_q <= rx_byte;
		end
	end

	// completed frame record
	always_comb begin
		for (int i = 0; i < ifp_pkg::WORD_COUNT; i++) begin
			frame.words[i] = words_q[i];
		end
		frame.status = status_q;
		frame.ck_ok  = ({rx_byte, ck_low_q} == sum_q);
	end

	assign stat.pos  = pos_q;
	assign stat.emit = emit;

endmodule

@@ hdl/ifp_out_reg.sv @@
// ----------------------------------------------------------------------------
// ifp_out_reg
// Result register: holds one completed frame until the consumer takes it.
// ----------------------------------------------------------------------------
module ifp_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ifp_pkg::frame_t frame_in,
	input  logic            take,
	output logic            valid,
	output ifp_pkg::frame_t frame_out
);

	logic            valid_q;
	ifp_pkg::frame_t frame_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_in;
		end
	end

	assign valid     = valid_q;
	assign frame_out = frame_q;

endmodule

@@ hdl/imu_serial_frame_parser_top.sv @@
// Result: a frame's result is registered and valid in the cycle after its last checksum byte is accepted.
// Throughput: one byte per cycle; the byte tracker and single result register
// allow a new byte every cycle while the result register is empty or drained.
// Reset: arst_n clears the position (hunting), sum and result valid, and sets
// the header register to 0xAA; no clearing pass is needed.
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_top
// Parses header-led imu frames from a serial byte stream into one result item.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         header_byte,
	// byte input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// frame output
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic [7:0]         device_status,
	output logic               checksum_ok
);

	ifp_pkg::frame_t      frame_new;
	ifp_pkg::frame_t      frame_out;
	ifp_pkg::parse_stat_t stat;
	logic                 accept;

	// a byte is taken whenever the result slot is free or being emptied
	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign accept    = in_valid && in_ready;

	ifp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (header_byte),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.frame    (frame_new),
		.stat     (stat)
	);

	ifp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (stat.emit),
		.frame_in  (frame_new),
		.take      (out_ready),
		.valid     (out_valid),
		.frame_out (frame_out)
	);

	// result fields
	assign gyro_x        = signed'(frame_out.words[ifp_pkg::IDX_GYRO_X]);
	assign gyro_y        = signed'(frame_out.words[ifp_pkg::IDX_GYRO_Y]);
	assign gyro_z        = signed'(frame_out.words[ifp_pkg::IDX_GYRO_Z]);
	assign accel_x       = signed'(frame_out.words[ifp_pkg::IDX_ACCEL_X]);
	assign accel_y       = signed'(frame_out.words[ifp_pkg::IDX_ACCEL_Y]);
	assign accel_z       = signed'(frame_out.words[ifp_pkg::IDX_ACCEL_Z]);
	assign roll_angle    = signed'(frame_out.words[ifp_pkg::IDX_ROLL]);
	assign pitch_angle   = signed'(frame_out.words[ifp_pkg::IDX_PITCH]);
	assign yaw_angle     = signed'(frame_out.words[ifp_pkg::IDX_YAW]);
	assign device_status = frame_out.status;
	assign checksum_ok   = frame_out.ck_ok;

	// position stays inside the frame layout
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pos <= ifp_pkg::POS_FRAME_LAST)
		else $error("byte position outside frame layout");

	// the last checksum byte always produces a result next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |=> out_valid)
		else $error("completed frame not presented");

	// a frame is only built from an accepted byte
	a_emit_accept: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> accept)
		else $error("frame emitted without an accepted byte");

	// after a completed frame the tracker is back to hunting
	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |=> stat.pos == ifp_pkg::POS_HUNT)
		else $error("tracker did not return to hunting");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the imu serial frame parser against a cycle-free frame predictor.
// A directed frame covers the word extremes and a header value inside the
// data. Random byte streams follow: mostly whole frames, some with a bad
// checksum, plus stray bytes and cut-off frames that break the alignment.
// The streams run under four header settings and four idle mixes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_BYTES = ifp_pkg::POS_FRAME_LAST + 1;

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [7:0]         header_byte   = ifp_pkg::HEADER_RESET;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte       = 8'h00;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic [7:0]         device_status;
	logic               checksum_ok;

	// idle mix of the current phase, in percent per cycle
	int in_idle_pct   = 0;
	int out_stall_pct = 0;

	// run statistics
	int error_count      = 0;
	int bytes_sent       = 0;
	int frames_predicted = 0;
	int frames_checked   = 0;

	// frame predictor state
	logic [7:0]                ifp_hdr_dummy_unused_guard;
	logic [7:0]                hdr_cfg    = ifp_pkg::HEADER_RESET;
	logic [ifp_pkg::POS_W-1:0] parse_pos  = ifp_pkg::POS_HUNT;
	logic [15:0]               parse_sum  = 16'h0000;
	logic [7:0]                ck_low     = 8'h00;
	logic [ifp_pkg::WORD_COUNT-1:0][15:0] word_buf = '0;
	logic [7:0]                status_buf = 8'h00;
	ifp_pkg::frame_t           frames_due [$];

	string field_names [ifp_pkg::WORD_COUNT] = '{"gyro_x", "gyro_y", "gyro_z",
		"accel_x", "accel_y", "accel_z", "roll_angle", "pitch_angle", "yaw_angle"};

	imu_serial_frame_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.header_byte   (header_byte),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gyro_x        (gyro_x),
		.gyro_y        (gyro_y),
		.gyro_z        (gyro_z),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.roll_angle    (roll_angle),
		.pitch_angle   (pitch_angle),
		.yaw_angle     (yaw_angle),
		.device_status (device_status),
		.checksum_ok   (checksum_ok)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d frames still awaited", frames_due.size());
		$display("Mismatches found");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t frame %0d: %s", $time, frames_checked, msg);
		error_count++;
	endtask

	// advance the predictor by one accepted byte
	function automatic void parse_byte(input logic [7:0] b);
		ifp_pkg::frame_t f;
		int              widx;
		if (parse_pos == ifp_pkg::POS_HUNT) begin
			if (b == hdr_cfg) begin
				parse_pos = ifp_pkg::POS_HUNT + 1'b1;
				parse_sum = {8'h00, b};
			end
		end else if (parse_pos <= ifp_pkg::POS_WORD_LAST) begin
			widx = (int'(parse_pos) - 1) / 2;
			if (parse_pos[0]) begin
				word_buf[widx] = {b, 8'h00};
				parse_sum      = parse_sum + {b, 8'h00};
			end else begin
				word_buf[widx][7:0] = b;
				parse_sum           = parse_sum + {8'h00, b};
			end
			parse_pos = parse_pos + 1'b1;
		end else if (parse_pos == ifp_pkg::POS_STATUS) begin
			status_buf = b;
			parse_sum  = parse_sum + {b, 8'h00};
			parse_pos  = parse_pos + 1'b1;
		end else if (parse_pos == ifp_pkg::POS_CK_LOW) begin
			ck_low    = b;
			parse_pos = parse_pos + 1'b1;
		end else if (parse_pos == ifp_pkg::POS_FRAME_LAST) begin
			f.words   = word_buf;
			f.status  = status_buf;
			f.ck_ok   = ({b, ck_low} == parse_sum);
			frames_due.push_back(f);
			frames_predicted++;
			parse_pos = ifp_pkg::POS_HUNT;
		end else begin
			// positions past the frame end fall back to hunting
			parse_pos = ifp_pkg::POS_HUNT;
		end
	endfunction

	// watch accepted bytes and register writes; a byte meets the old header
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			if (cfg_valid && cfg_ready)
				hdr_cfg = header_byte;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// compare each accepted frame with the oldest prediction
	always @(posedge clk) begin : check_frames
		ifp_pkg::frame_t got;
		ifp_pkg::frame_t want;
		if (arst_n && out_valid && out_ready) begin
			got.words[ifp_pkg::IDX_GYRO_X]  = gyro_x;
			got.words[ifp_pkg::IDX_GYRO_Y]  = gyro_y;
			got.words[ifp_pkg::IDX_GYRO_Z]  = gyro_z;
			got.words[ifp_pkg::IDX_ACCEL_X] = accel_x;
			got.words[ifp_pkg::IDX_ACCEL_Y] = accel_y;
			got.words[ifp_pkg::IDX_ACCEL_Z] = accel_z;
			got.words[ifp_pkg::IDX_ROLL]    = roll_angle;
			got.words[ifp_pkg::IDX_PITCH]   = pitch_angle;
			got.words[ifp_pkg::IDX_YAW]     = yaw_angle;
			got.status                      = device_status;
			got.ck_ok                       = checksum_ok;
			if (frames_due.size() == 0) begin
				report_error("frame with none predicted");
			end else begin
				want = frames_due.pop_front();
				for (int i = 0; i < ifp_pkg::WORD_COUNT; i++)
					if (got.words[i] !== want.words[i])
						report_error($sformatf("%s got %0d expected %0d", field_names[i],
							$signed(got.words[i]), $signed(want.words[i])));
				if (got.status !== want.status)
					report_error($sformatf("device_status got %0h expected %0h",
						got.status, want.status));
				if (got.ck_ok !== want.ck_ok)
					report_error($sformatf("checksum_ok got %0b expected %0b",
						got.ck_ok, want.ck_ok));
			end
			frames_checked++;
		end
	end

	// one byte item, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// build a frame for the current header and send its first n_send bytes
	task automatic send_frame(input logic [ifp_pkg::WORD_COUNT-1:0][15:0] w,
		input logic [7:0] st, input int n_send, input bit bad_ck);
		logic [7:0]  seq [$];
		logic [15:0] ck;
		ck = {8'h00, header_byte};
		seq.push_back(header_byte);
		for (int i = 0; i < ifp_pkg::WORD_COUNT; i++) begin
			seq.push_back(w[i][15:8]);
			seq.push_back(w[i][7:0]);
			ck = ck + w[i];
		end
		seq.push_back(st);
		ck = ck + {st, 8'h00};
		if (bad_ck)
			ck = ck ^ 16'($urandom_range(1, 65535));
		seq.push_back(ck[7:0]);
		seq.push_back(ck[15:8]);
		for (int i = 0; i < n_send; i++)
			send_byte(seq[i]);
	endtask

	task automatic write_header(input logic [7:0] v);
		cfg_valid   <= 1'b1;
		header_byte <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and wait for every predicted frame
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly whole frames, some stray bytes and cut-off frames
	task automatic run_random_stream(input int n_bytes, input int n_frames);
		int          byte_mark;
		int          frame_mark;
		int          pick;
		logic [15:0] corner [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		logic [ifp_pkg::WORD_COUNT-1:0][15:0] w;
		byte_mark  = bytes_sent;
		frame_mark = frames_predicted;
		while (bytes_sent - byte_mark < n_bytes || frames_predicted - frame_mark < n_frames) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				for (int i = 0; i < ifp_pkg::WORD_COUNT; i++)
					w[i] = ($urandom_range(7) == 0) ? corner[$urandom_range(3)]
						: 16'($urandom);
				if (pick < 70)
					send_frame(w, 8'($urandom), FRAME_BYTES, $urandom_range(3) == 0);
				else
					send_frame(w, 8'($urandom), $urandom_range(1, FRAME_BYTES - 1), 1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
	endtask

	// stray bytes while hunting, then one frame of extreme words
	task automatic test_directed_frame();
		logic [ifp_pkg::WORD_COUNT-1:0][15:0] w;
		in_idle_pct   = 0;
		out_stall_pct = 0;
		w[ifp_pkg::IDX_GYRO_X]  = 16'h8000;
		w[ifp_pkg::IDX_GYRO_Y]  = 16'h7FFF;
		w[ifp_pkg::IDX_GYRO_Z]  = 16'h0000;
		w[ifp_pkg::IDX_ACCEL_X] = 16'hFFFF;
		w[ifp_pkg::IDX_ACCEL_Y] = {ifp_pkg::HEADER_RESET, ifp_pkg::HEADER_RESET};
		w[ifp_pkg::IDX_ACCEL_Z] = 16'h00AA;
		w[ifp_pkg::IDX_ROLL]    = 16'hAA00;
		w[ifp_pkg::IDX_PITCH]   = 16'h0001;
		w[ifp_pkg::IDX_YAW]     = 16'hFFFE;
		send_byte(8'h00);
		send_byte(8'h55);
		send_frame(w, 8'hFF, FRAME_BYTES, 1'b0);
		settle();
	endtask

	task automatic test_no_idle();
		write_header(8'h00);
		in_idle_pct   = 0;
		out_stall_pct = 0;
		run_random_stream(200, 6);
		settle();
	endtask

	task automatic test_sender_gaps();
		write_header(8'hFF);
		in_idle_pct   = 63;
		out_stall_pct = 0;
		run_random_stream(200, 6);
		settle();
	endtask

	task automatic test_receiver_stalls();
		write_header(8'($urandom_range(255)));
		in_idle_pct   = 0;
		out_stall_pct = 63;
		run_random_stream(200, 6);
		settle();
	endtask

	task automatic test_mixed_idle();
		write_header(ifp_pkg::HEADER_RESET);
		in_idle_pct   = 10;
		out_stall_pct = 10;
		run_random_stream(200, 6);
		settle();
	endtask

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frame();
		test_no_idle();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idle();
		$display("sent %0d bytes, checked %0d frames", bytes_sent, frames_checked);
		$display("headers 0xAA, 0x00, 0xFF and random; idle mixes none, sender, receiver, both");
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
